/* rtl/mp2_pkg.sv */
// Shared types and constants for the streaming 2-D max pooling block.
// Used by mp2_cfg, mp2_ctrl, mp2_dp and the top level under rtl; depends on nothing else.

package mp2_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int POS_BITS    = 10;
    localparam int COL_BITS    = 11;
    localparam int SLOT_BITS   = 3;
    localparam int ADDR_BITS   = SLOT_BITS + COL_BITS;
    localparam int RAM_DEPTH   = 1 << ADDR_BITS;
    localparam int GEO_BITS    = 13;
    localparam int MAX_KERNEL  = 8;
    localparam int PAD_CAP     = 6;
    localparam int MAX_DIM     = 1024;
    localparam int PADDR_BITS  = 5;

    typedef enum logic [2:0] {
        REG_KERNEL  = 3'd0,
        REG_STRIDE  = 3'd1,
        REG_PADDING = 3'd2,
        REG_HEIGHT  = 3'd3,
        REG_WIDTH   = 3'd4
    } t_reg_idx;

    typedef logic signed [GEO_BITS-1:0] t_geo;

    typedef struct packed {
        logic [3:0]          k;
        logic [3:0]          s;
        logic [3:0]          e_init;
        logic [POS_BITS-1:0] hm1;
        logic [POS_BITS-1:0] wm1;
        t_geo                hp;
        t_geo                wp;
    } t_geom;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_COL,
        ST_UPD,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic accept;
        logic col_init;
        logic next_row;
        logic rd;
        logic upd;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic row_ok;
        logic col_ok;
        logic need_out;
        logic pend_valid;
        logic out_free;
    } t_stat;

endpackage

/* rtl/mp2_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module mp2_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/mp2_cfg.sv */
// Configuration registers on the APB-style port, with clamped geometry.
// Depends on mp2_pkg.

module mp2_cfg
    import mp2_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  o_cfg_wr,
    output t_geom                 o_geom
);

    logic [3:0]  r_kernel;
    logic [3:0]  r_stride;
    logic [2:0]  r_pad;
    logic [10:0] r_height;
    logic [10:0] r_width;

    logic        wr;
    logic        listed;
    logic [3:0]  k;
    logic [2:0]  km1;
    logic [2:0]  p;
    logic [10:0] h;
    logic [10:0] w;

    assign wr = psel && penable && pwrite;

    always_comb begin
        listed = 1'b0;
        unique case (paddr[4:2])
            REG_KERNEL, REG_STRIDE, REG_PADDING, REG_HEIGHT, REG_WIDTH: listed = 1'b1;
            default: listed = 1'b0;
        endcase
    end

    assign o_cfg_wr = wr && listed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel <= 4'd2;
            r_stride <= 4'd0;
            r_pad    <= 3'd0;
            r_height <= 11'd8;
            r_width  <= 11'd8;
        end else if (wr) begin
            unique case (paddr[4:2])
                REG_KERNEL:  r_kernel <= pwdata[3:0];
                REG_STRIDE:  r_stride <= pwdata[3:0];
                REG_PADDING: r_pad    <= pwdata[2:0];
                REG_HEIGHT:  r_height <= pwdata[10:0];
                REG_WIDTH:   r_width  <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = 32'd0;
        unique case (paddr[4:2])
            REG_KERNEL:  prdata = {28'd0, r_kernel};
            REG_STRIDE:  prdata = {28'd0, r_stride};
            REG_PADDING: prdata = {29'd0, r_pad};
            REG_HEIGHT:  prdata = {21'd0, r_height};
            REG_WIDTH:   prdata = {21'd0, r_width};
            default:     prdata = 32'd0;
        endcase
    end

    always_comb begin
        k = r_kernel;
        if (r_kernel == 4'd0) begin
            k = 4'd1;
        end else if (r_kernel > 4'(MAX_KERNEL)) begin
            k = 4'(MAX_KERNEL);
        end
        km1 = 3'(k - 4'd1);
        p = r_pad;
        if (p > km1) begin
            p = km1;
        end
        if (p > 3'(PAD_CAP)) begin
            p = 3'(PAD_CAP);
        end
        h = r_height;
        if (r_height == 11'd0) begin
            h = 11'd1;
        end else if (r_height > 11'(MAX_DIM)) begin
            h = 11'(MAX_DIM);
        end
        w = r_width;
        if (r_width == 11'd0) begin
            w = 11'd1;
        end else if (r_width > 11'(MAX_DIM)) begin
            w = 11'(MAX_DIM);
        end
    end

    always_comb begin
        o_geom.k      = k;
        o_geom.s      = (r_stride == 4'd0) ? k : r_stride;
        o_geom.e_init = 4'({1'b0, km1} - {1'b0, p});
        o_geom.hm1    = POS_BITS'(h - 11'd1);
        o_geom.wm1    = POS_BITS'(w - 11'd1);
        o_geom.hp     = {3'd0, o_geom.hm1} + {10'd0, p};
        o_geom.wp     = {3'd0, o_geom.wm1} + {10'd0, p};
    end

endmodule

/* rtl/mp2_ctrl.sv */
// Controller state machine that sequences the window walk for each sample.
// Depends on mp2_pkg.

module mp2_ctrl
    import mp2_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_ROW;
                end
            end
            ST_ROW: begin
                n_state = i_stat.row_ok ? ST_COL : ST_FLUSH;
            end
            ST_COL: begin
                n_state = i_stat.col_ok ? ST_UPD : ST_ROW;
            end
            ST_UPD: begin
                if (!(i_stat.need_out && !i_stat.out_free)) begin
                    n_state = ST_COL;
                end
            end
            ST_FLUSH: begin
                if (!(i_stat.pend_valid && !i_stat.out_free)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_ROW: begin
                o_cmd.col_init = i_stat.row_ok;
            end
            ST_COL: begin
                o_cmd.rd       = i_stat.col_ok;
                o_cmd.next_row = !i_stat.col_ok;
            end
            ST_UPD: begin
                o_cmd.upd = !(i_stat.need_out && !i_stat.out_free);
            end
            ST_FLUSH: begin
                o_cmd.flush = !(i_stat.pend_valid && !i_stat.out_free);
            end
            default: ;
        endcase
    end

endmodule

/* rtl/mp2_dp.sv */
// Datapath: plane position, window trackers, partial maximum store and result staging.
// Depends on mp2_pkg and mp2_ram.

module mp2_dp
    import mp2_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_geom                         i_geom,
    input  logic                          i_cfg_wr,
    input  t_cmd                          i_cmd,
    output t_stat                         o_stat,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [SAMPLE_BITS-1:0] o_pooled_value,
    output logic                          o_plane_end,
    output logic                          o_run_last
);

    logic                          r_origin;
    logic [POS_BITS-1:0]           r_row;
    logic [POS_BITS-1:0]           r_col;
    logic [3:0]                    r_er;
    logic [3:0]                    r_ec;
    logic [SLOT_BITS-1:0]          r_lor;
    logic [COL_BITS-1:0]           r_loc;
    logic signed [SAMPLE_BITS-1:0] r_x;
    t_geo                          r_rs;
    t_geo                          r_cs;
    logic [SLOT_BITS-1:0]          r_oh;
    logic [COL_BITS-1:0]           r_ow;
    logic                          r_pend_valid;
    logic signed [SAMPLE_BITS-1:0] r_pend_v;
    logic                          r_pend_pe;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_v;
    logic                          r_out_pe;
    logic                          r_out_last;

    logic [POS_BITS-1:0]           cur_row;
    logic [POS_BITS-1:0]           cur_col;
    logic [3:0]                    cur_er;
    logic [3:0]                    cur_ec;
    logic [SLOT_BITS-1:0]          cur_lor;
    logic [COL_BITS-1:0]           cur_loc;
    t_geo                          g_row;
    t_geo                          g_col;
    t_geo                          g_km1;
    t_geo                          g_s;
    t_geo                          g_hm1;
    t_geo                          g_wm1;
    t_geo                          row_end;
    t_geo                          col_end;
    logic                          row_first;
    logic                          col_first;
    logic                          row_close;
    logic                          col_close;
    logic                          row_lastwin;
    logic                          col_lastwin;
    logic                          closing;
    logic                          out_free;
    logic                          push;
    logic signed [SAMPLE_BITS-1:0] rdata;
    logic signed [SAMPLE_BITS-1:0] v;
    logic [ADDR_BITS-1:0]          addr;

    assign cur_row = r_origin ? '0 : r_row;
    assign cur_col = r_origin ? '0 : r_col;
    assign cur_er  = r_origin ? i_geom.e_init : r_er;
    assign cur_ec  = r_origin ? i_geom.e_init : r_ec;
    assign cur_lor = r_origin ? '0 : r_lor;
    assign cur_loc = r_origin ? '0 : r_loc;

    assign g_row = {3'd0, cur_row};
    assign g_col = {3'd0, cur_col};
    assign g_km1 = {9'd0, 4'(i_geom.k - 4'd1)};
    assign g_s   = {9'd0, i_geom.s};
    assign g_hm1 = {3'd0, i_geom.hm1};
    assign g_wm1 = {3'd0, i_geom.wm1};

    assign row_end     = r_rs + g_km1;
    assign col_end     = r_cs + g_km1;
    assign row_first   = (r_rs < 0) ? (cur_row == '0) : (r_rs == g_row);
    assign col_first   = (r_cs < 0) ? (cur_col == '0) : (r_cs == g_col);
    assign row_close   = (row_end > g_hm1) ? (g_row == g_hm1) : (row_end == g_row);
    assign col_close   = (col_end > g_wm1) ? (g_col == g_wm1) : (col_end == g_col);
    assign row_lastwin = (row_end + g_s) > i_geom.hp;
    assign col_lastwin = (col_end + g_s) > i_geom.wp;
    assign closing     = row_close && col_close;

    assign addr = {r_oh, r_ow};

    mp2_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(RAM_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.upd),
        .i_waddr(addr),
        .i_wdata(v),
        .i_re   (i_cmd.rd),
        .i_raddr(addr),
        .o_rdata(rdata)
    );

    always_comb begin
        if (row_first && col_first) begin
            v = r_x;
        end else begin
            v = (rdata > r_x) ? rdata : r_x;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign push     = r_pend_valid && ((i_cmd.upd && closing) || i_cmd.flush);

    assign o_stat.row_ok     = (r_rs <= g_row) && (row_end <= i_geom.hp);
    assign o_stat.col_ok     = (r_cs <= g_col) && (col_end <= i_geom.wp);
    assign o_stat.need_out   = closing && r_pend_valid;
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.out_free   = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin <= 1'b1;
            r_row    <= '0;
            r_col    <= '0;
            r_lor    <= '0;
            r_loc    <= '0;
        end else if (i_cfg_wr) begin
            r_origin <= 1'b1;
        end else if (i_cmd.flush) begin
            r_origin <= 1'b0;
            if (cur_col == i_geom.wm1) begin
                r_col <= '0;
                r_ec  <= i_geom.e_init;
                r_loc <= '0;
                if (cur_row == i_geom.hm1) begin
                    r_row <= '0;
                    r_er  <= i_geom.e_init;
                    r_lor <= '0;
                end else begin
                    r_row <= cur_row + 1'b1;
                    r_er  <= (cur_er == 4'd0) ? 4'(i_geom.s - 4'd1) : 4'(cur_er - 4'd1);
                    r_lor <= (cur_er == 4'd0) ? SLOT_BITS'(cur_lor + 1'b1) : cur_lor;
                end
            end else begin
                r_col <= cur_col + 1'b1;
                r_row <= cur_row;
                r_er  <= cur_er;
                r_lor <= cur_lor;
                r_ec  <= (cur_ec == 4'd0) ? 4'(i_geom.s - 4'd1) : 4'(cur_ec - 4'd1);
                r_loc <= (cur_ec == 4'd0) ? COL_BITS'(cur_loc + 1'b1) : cur_loc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x  <= i_sample;
            r_rs <= g_row + {9'd0, cur_er} - g_km1;
            r_oh <= cur_lor;
        end else if (i_cmd.next_row) begin
            r_rs <= r_rs + g_s;
            r_oh <= SLOT_BITS'(r_oh + 1'b1);
        end
        if (i_cmd.col_init) begin
            r_cs <= g_col + {9'd0, cur_ec} - g_km1;
            r_ow <= cur_loc;
        end else if (i_cmd.upd) begin
            r_cs <= r_cs + g_s;
            r_ow <= COL_BITS'(r_ow + 1'b1);
        end
        if (i_cmd.upd && closing) begin
            r_pend_v  <= v;
            r_pend_pe <= row_lastwin && col_lastwin;
        end
        if (push) begin
            r_out_v    <= r_pend_v;
            r_out_pe   <= r_pend_pe;
            r_out_last <= i_cmd.flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.upd && closing) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pooled_value = r_out_v;
    assign o_plane_end    = r_out_pe;
    assign o_run_last     = r_out_last;

endmodule

/* rtl/max_pool_2d_stream.sv */
// Top level of the streaming 2-D max pooling block.
// Depends on mp2_pkg, mp2_cfg, mp2_ctrl and mp2_dp.
//
//   Channel   Direction  Handshake                     Payload
//   input     in         i_in_valid / o_in_ready       i_sample
//   output    out        o_out_valid / i_out_ready     o_pooled_value, o_plane_end, o_run_last
//   config    in         psel, penable, pwrite, pready paddr, pwdata, prdata
//
// Each sample is walked over the window rows it touches and the windows it
// updates; each window costs one store read and one store write on the single
// partial maximum RAM. A new sample is accepted only once the walk for the last
// one is back in idle. Reset is synchronous; the store needs no clearing pass.
// A full output register stalls the walk only when a second result is waiting.

module max_pool_2d_stream
    import mp2_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_pooled_value,
    output logic                          o_plane_end,
    output logic                          o_run_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PADDR_BITS-1:0]         paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    t_geom geom;
    t_cmd  cmd;
    t_stat stat;
    logic  cfg_wr;

    assign pready = 1'b1;

    mp2_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg_wr(cfg_wr),
        .o_geom  (geom)
    );

    mp2_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    mp2_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_geom        (geom),
        .i_cfg_wr      (cfg_wr),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_sample      (i_sample),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_pooled_value(o_pooled_value),
        .o_plane_end   (o_plane_end),
        .o_run_last    (o_run_last)
    );

endmodule

/* bench/tb_max_pool_2d_stream.sv */
// Self-checking testbench for max_pool_2d_stream: a directed table of samples, then random
// configuration phases, each result checked against an in-bench pooling predictor or the table.
// Depends on mp2_pkg and the RTL under rtl.

module tb_max_pool_2d_stream;
    import mp2_pkg::*;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          plane_end;
        logic                          run_last;
    } t_pool_res;

    typedef enum int {
        ROW_CFG,
        ROW_SMP,
        ROW_SMP_EXP
    } t_row_kind;

    typedef struct {
        t_row_kind                     kind;
        int                            k, s, p, h, w;
        logic signed [SAMPLE_BITS-1:0] smp;
        logic signed [SAMPLE_BITS-1:0] exp_value;
        logic                          exp_end;
    } t_dir_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic signed [SAMPLE_BITS-1:0] i_sample = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_pooled_value;
    logic                          o_plane_end;
    logic                          o_run_last;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [PADDR_BITS-1:0]         paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    max_pool_2d_stream dut (.*);

    t_pool_res                     pooled_q[$];
    logic signed [SAMPLE_BITS-1:0] window_max [0:MAX_KERNEL-1][0:MAX_DIM+MAX_KERNEL-1];
    int cfg_k = 2, cfg_s = 0, cfg_p = 0, cfg_h = 8, cfg_w = 8;
    int row_pos = 0, col_pos = 0;
    int mismatches = 0, results_seen = 0, samples_sent = 0, phases = 0;
    bit quiet = 0;
    t_dir_row dir_tbl[$];

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #12000000;
        $display("Timeout with %0d results still expected.", pooled_q.size());
        $display("== FAIL ==");
        $finish;
    end

    function automatic int clamp_dim(int v);
        if (v < 1) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    task automatic pool_predict(input logic signed [SAMPLE_BITS-1:0] x);
        int k, s, p, h, w, ohn, own, r, c, lor, hir, loc, hic, t;
        int sr, fr, lr, sc, fc, lc, n;
        logic signed [SAMPLE_BITS-1:0] v;
        t_pool_res e;
        k = cfg_k;
        if (k < 1) k = 1;
        if (k > MAX_KERNEL) k = MAX_KERNEL;
        s = (cfg_s == 0) ? k : cfg_s;
        p = cfg_p;
        if (p > k - 1) p = k - 1;
        if (p > PAD_CAP) p = PAD_CAP;
        h = clamp_dim(cfg_h);
        w = clamp_dim(cfg_w);
        ohn = (h + 2 * p - k < 0) ? 0 : (h + 2 * p - k) / s + 1;
        own = (w + 2 * p - k < 0) ? 0 : (w + 2 * p - k) / s + 1;
        r = (row_pos >= h) ? 0 : row_pos;
        c = (col_pos >= w) ? 0 : col_pos;
        n = 0;
        if (ohn > 0 && own > 0) begin
            t = r + p - (k - 1);
            lor = (t <= 0) ? 0 : (t + s - 1) / s;
            hir = (r + p) / s;
            if (hir > ohn - 1) hir = ohn - 1;
            t = c + p - (k - 1);
            loc = (t <= 0) ? 0 : (t + s - 1) / s;
            hic = (c + p) / s;
            if (hic > own - 1) hic = own - 1;
            for (int oh = lor; oh <= hir; oh++) begin
                sr = oh * s - p;
                fr = (sr < 0) ? 0 : sr;
                lr = (sr + k - 1 > h - 1) ? h - 1 : sr + k - 1;
                for (int ow = loc; ow <= hic; ow++) begin
                    sc = ow * s - p;
                    fc = (sc < 0) ? 0 : sc;
                    lc = (sc + k - 1 > w - 1) ? w - 1 : sc + k - 1;
                    if (r == fr && c == fc) v = x;
                    else v = (window_max[oh % MAX_KERNEL][ow] > x) ?
                             window_max[oh % MAX_KERNEL][ow] : x;
                    window_max[oh % MAX_KERNEL][ow] = v;
                    if (r == lr && c == lc) begin
                        e.value = v;
                        e.plane_end = (oh == ohn - 1 && ow == own - 1);
                        e.run_last = 1'b0;
                        pooled_q.push_back(e);
                        n++;
                    end
                end
            end
            if (n > 0) pooled_q[pooled_q.size() - 1].run_last = 1'b1;
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        row_pos = r;
        col_pos = c;
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_BITS'(4 * int'(idx));
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_KERNEL:  cfg_k = data & 32'hF;
            REG_STRIDE:  cfg_s = data & 32'hF;
            REG_PADDING: cfg_p = data & 32'h7;
            REG_HEIGHT:  cfg_h = data & 32'h7FF;
            REG_WIDTH:   cfg_w = data & 32'h7FF;
            default: ;
        endcase
        row_pos = 0;
        col_pos = 0;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pooled_q.size() != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    task automatic configure(input int k, input int s, input int p, input int h, input int w);
        wait_idle();
        apb_write(REG_KERNEL, k);
        apb_write(REG_STRIDE, s);
        apb_write(REG_PADDING, p);
        apb_write(REG_HEIGHT, h);
        apb_write(REG_WIDTH, w);
        phases++;
    endtask

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample <= x;
        do @(posedge i_clk); while (!o_in_ready);
        pool_predict(x);
        samples_sent++;
        @(negedge i_clk);
    endtask

    task automatic add_cfg(input int k, input int s, input int p, input int h, input int w);
        t_dir_row row;
        row.kind = ROW_CFG;
        row.k = k; row.s = s; row.p = p; row.h = h; row.w = w;
        dir_tbl.push_back(row);
    endtask

    task automatic add_smp(input t_row_kind kind, input logic signed [SAMPLE_BITS-1:0] x,
                           input logic signed [SAMPLE_BITS-1:0] ev, input logic ee);
        t_dir_row row;
        row.kind = kind;
        row.smp = x;
        row.exp_value = ev;
        row.exp_end = ee;
        dir_tbl.push_back(row);
    endtask

    initial begin
        int gap;
        forever begin
            @(negedge i_clk);
            gap = quiet ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        t_pool_res e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pooled_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result %0d at %0t.", o_pooled_value, $realtime);
            end else begin
                e = pooled_q.pop_front();
                if (o_pooled_value !== e.value || o_plane_end !== e.plane_end ||
                    o_run_last !== e.run_last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch at %0t: expected %0d/%0b/%0b, got %0d/%0b/%0b.",
                                 $realtime, e.value, e.plane_end, e.run_last,
                                 o_pooled_value, o_plane_end, o_run_last);
                end
            end
        end
    end

    initial begin
        int k, s, p, h, w, n, sel;
        logic signed [SAMPLE_BITS-1:0] x;
        add_cfg(2, 0, 0, 2, 2);
        add_smp(ROW_SMP, -16'sd32768, 0, 0);
        add_smp(ROW_SMP, 16'sd32767, 0, 0);
        add_smp(ROW_SMP, 16'sd0, 0, 0);
        add_smp(ROW_SMP_EXP, -16'sd1, 16'sd32767, 1'b1);
        for (int i = 0; i < 4; i++)
            add_smp(i == 3 ? ROW_SMP_EXP : ROW_SMP, -16'sd32768, -16'sd32768, 1'b1);
        add_cfg(15, 0, 7, 1, 1);
        add_smp(ROW_SMP_EXP, 16'sd5, 16'sd5, 1'b1);
        add_cfg(3, 1, 2, 3, 3);
        for (int i = 0; i < 9; i++) add_smp(ROW_SMP, 16'(i * 1111 - 4000), 0, 0);
        add_cfg(8, 0, 0, 3, 3);
        for (int i = 0; i < 3; i++) add_smp(ROW_SMP, 16'(i), 0, 0);

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tbl[i]) begin
            if (dir_tbl[i].kind == ROW_CFG) begin
                i_in_valid <= 1'b0;
                configure(dir_tbl[i].k, dir_tbl[i].s, dir_tbl[i].p, dir_tbl[i].h,
                          dir_tbl[i].w);
            end else begin
                send_sample(dir_tbl[i].smp);
                if (dir_tbl[i].kind == ROW_SMP_EXP) begin
                    pooled_q[pooled_q.size() - 1].value = dir_tbl[i].exp_value;
                    pooled_q[pooled_q.size() - 1].plane_end = dir_tbl[i].exp_end;
                end
            end
        end

        while (samples_sent < 390) begin
            k = $urandom_range(0, 15);
            s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
            p = $urandom_range(0, 7);
            sel = $urandom_range(0, 9);
            h = (sel == 0) ? $urandom_range(0, 1) : (sel == 1) ? 2047 : $urandom_range(1, 12);
            sel = $urandom_range(0, 9);
            w = (sel == 0) ? $urandom_range(0, 1) : (sel == 1) ? 1024 : $urandom_range(1, 12);
            if ($urandom_range(0, 4) == 0) begin
                k = 8; s = 1; p = 6; h = 7; w = 7;
            end
            i_in_valid <= 1'b0;
            configure(k | ($urandom() & 32'hFFFF_FFF0), s, p, h, w);
            quiet = ($urandom_range(0, 3) == 0);
            n = $urandom_range(20, 60);
            for (int i = 0; i < n; i++) begin
                sel = $urandom_range(0, 9);
                x = (sel == 0) ? 16'h8000 : (sel == 1) ? 16'h7FFF : 16'($urandom());
                send_sample(x);
            end
            quiet = 0;
        end
        i_in_valid <= 1'b0;

        wait_idle();
        $display("Sent %0d samples over %0d configuration phases, checked %0d results.",
                 samples_sent, phases, results_seen);
        $display("Mismatches: %0d, results left unmatched: %0d.", mismatches, pooled_q.size());
        if (mismatches == 0 && pooled_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
